@@ rtl/tachometer_auto_threshold_defines.svh @@
// Assertion macros for the checker file.
`ifndef TACHOMETER_AUTO_THRESHOLD_DEFINES_SVH
`define TACHOMETER_AUTO_THRESHOLD_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define TAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define TAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TAT_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tat_pkg.sv @@
`default_nettype none

package tat_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int WINDOW_W    = 16;
  localparam int RPM_W       = 21;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WINDOW_W-1:0] MEASURE_WINDOW_RESET = 16'd2048;
  localparam logic [WINDOW_W-1:0] CALIB_WINDOW_RESET   = 16'd512;
  localparam logic [SAMPLE_W-1:0] INIT_THRESHOLD_RESET = 10'd295;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX           = 10'd1023;
  localparam logic [WINDOW_W-1:0] BREAK_MAX            = 16'hFFFF;
  localparam logic [RPM_W-1:0]    RPM_FACTOR           = 21'd60;
  localparam logic [RPM_W-1:0]    RPM_MAX              = 21'd1966020;

  localparam logic REQ_PRESS = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_CALIB   = 2'd1,
    MODE_MEASURE = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEASURE_WINDOW = 2'd0,
    REG_CALIB_WINDOW   = 2'd1,
    REG_INIT_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [RPM_W-1:0]    rpm;
    logic [SAMPLE_W-1:0] last_sample;
    logic [SAMPLE_W-1:0] threshold_now;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/tat_core.sv @@
`default_nettype none

module tat_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  tat_pkg::in_t                     item,
  input  logic                             cfg_we,
  input  logic [tat_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tat_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             has_result,
  output tat_pkg::out_t                    result
);
  import tat_pkg::*;

  logic [WINDOW_W-1:0] measure_window;
  logic [WINDOW_W-1:0] calib_window;

  mode_t               mode, mode_next;
  logic [WINDOW_W-1:0] sample_count, sample_count_next;
  logic [WINDOW_W-1:0] break_count, break_count_next;
  logic [SAMPLE_W-1:0] threshold, threshold_next;
  logic [SAMPLE_W-1:0] min_seen, min_seen_next;
  logic [SAMPLE_W-1:0] max_seen, max_seen_next;

  logic [WINDOW_W-1:0] count_inc;
  logic [WINDOW_W-1:0] break_after;
  logic [SAMPLE_W-1:0] min_upd, max_upd;
  logic [SAMPLE_W:0]   mid_sum;
  logic                hit;

  always_comb begin
    count_inc   = sample_count + 16'd1;
    hit         = (item.sample == threshold) && (break_count != BREAK_MAX);
    break_after = hit ? (break_count + 16'd1) : break_count;
    max_upd     = (item.sample > max_seen) ? item.sample : max_seen;
    min_upd     = (item.sample < min_seen) ? item.sample : min_seen;
    mid_sum     = {1'b0, min_upd} + {1'b0, max_upd};

    mode_next         = mode;
    sample_count_next = sample_count;
    break_count_next  = break_count;
    threshold_next    = threshold;
    min_seen_next     = min_seen;
    max_seen_next     = max_seen;
    has_result        = 1'b0;

    result.rpm           = {6'd0, break_after[WINDOW_W-1:1]} * RPM_FACTOR;
    result.last_sample   = item.sample;
    result.threshold_now = threshold;

    if (step) begin
      if (item.req_type == REQ_PRESS) begin
        if (mode == MODE_STOPPED) begin
          mode_next         = MODE_CALIB;
          sample_count_next = '0;
        end else begin
          mode_next = MODE_STOPPED;
        end
      end else if (mode != MODE_STOPPED) begin
        sample_count_next = count_inc;
        break_count_next  = break_after;
        unique case (mode)
          MODE_CALIB: begin
            min_seen_next = min_upd;
            max_seen_next = max_upd;
            if (count_inc == calib_window) begin
              sample_count_next = '0;
              threshold_next    = mid_sum[SAMPLE_W:1];
              min_seen_next     = SAMPLE_MAX;
              max_seen_next     = '0;
              mode_next         = MODE_MEASURE;
            end
          end
          default: begin
            if (count_inc == measure_window) begin
              sample_count_next = '0;
              break_count_next  = '0;
              has_result        = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_STOPPED;
      sample_count <= '0;
      break_count  <= '0;
      threshold    <= INIT_THRESHOLD_RESET;
      min_seen     <= SAMPLE_MAX;
      max_seen     <= '0;
    end else begin
      mode         <= mode_next;
      sample_count <= sample_count_next;
      break_count  <= break_count_next;
      min_seen     <= min_seen_next;
      max_seen     <= max_seen_next;
      if (cfg_we && (cfg_reg_t'(cfg_index) == REG_INIT_THRESHOLD)) begin
        threshold <= cfg_data[SAMPLE_W-1:0];
      end else begin
        threshold <= threshold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_window <= MEASURE_WINDOW_RESET;
      calib_window   <= CALIB_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MEASURE_WINDOW: measure_window <= cfg_data[WINDOW_W-1:0];
        REG_CALIB_WINDOW:   calib_window   <= cfg_data[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/tat_obuf.sv @@
`default_nettype none

module tat_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tat_pkg::out_t push_data,
  output logic          push_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tat_pkg::out_t out_data
);
  import tat_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= push_data;
    end
    if (push && ((pop && skid_valid) || (!pop && out_valid))) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tachometer_auto_threshold.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data   (req_type, sample)
// out      out_valid / out_ready  out_data  (rpm, last_sample, threshold_now)
// cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle while the skid entry of the output buffer is empty.
// A result passes through the input register, then the output register.
// A two-entry output buffer keeps input flowing through an out stall until its skid entry fills.
// Synchronous reset returns to stopped mode with default windows and threshold.
`default_nettype none

module tachometer_auto_threshold (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tat_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tat_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [tat_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tat_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tat_pkg::*;

  logic inq_valid;
  in_t  inq_item;
  logic res_ready;
  logic step;
  logic has_result;
  out_t result;

  assign step     = inq_valid && res_ready;
  assign in_ready = !inq_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_item <= in_data;
    end
  end

  tat_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (inq_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .has_result (has_result),
    .result     (result)
  );

  tat_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (step && has_result),
    .push_data  (result),
    .push_ready (res_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/tat_checker.sv @@
`default_nettype none
`include "tachometer_auto_threshold_defines.svh"

module tat_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input tat_pkg::out_t out_data
);
  import tat_pkg::*;

  `TAT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled out item changed")
  `TAT_ASSERT_IMPLY(a_back_press, clk, rst, in_valid && !in_ready, out_valid, "input blocked with no out item pending")
  `TAT_ASSERT_IMPLY(a_rpm_range, clk, rst, out_valid, (out_data.rpm[1:0] == 2'd0) && (out_data.rpm <= RPM_MAX), "rpm out of range")
  `TAT_ASSERT_ALWAYS_NEXT(a_reset_clear, clk, rst, !out_valid && in_ready, "reset left the block busy")

endmodule

bind tachometer_auto_threshold tat_checker u_chk (.*);

`default_nettype wire

@@ verif/tach_reading_checker.sv @@
module tach_reading_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  tat_pkg::in_t                    in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tat_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [tat_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tat_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fails,
  output int                              pending
);
  import tat_pkg::*;

  logic [WINDOW_W-1:0] meas_win;
  logic [WINDOW_W-1:0] calib_win;
  logic [WINDOW_W-1:0] sample_cnt;
  logic [WINDOW_W-1:0] break_cnt;
  logic [SAMPLE_W-1:0] thresh;
  logic [SAMPLE_W-1:0] lo_seen;
  logic [SAMPLE_W-1:0] hi_seen;
  mode_t               run_mode;
  logic                was_calibrating;
  out_t                expected_readings [$];
  out_t                reading;
  out_t                want;

  function automatic bit advance_tach(input in_t item, output out_t res);
    res = '0;
    if (item.req_type == REQ_PRESS) begin
      if (run_mode == MODE_STOPPED) begin
        run_mode = MODE_CALIB;
        sample_cnt = '0;
        was_calibrating = 1'b0;
      end else begin
        was_calibrating = (run_mode == MODE_CALIB);
        run_mode = MODE_STOPPED;
      end
      return 1'b0;
    end
    if (run_mode == MODE_STOPPED) return 1'b0;

    sample_cnt = sample_cnt + 1'b1;
    if (item.sample == thresh && break_cnt != BREAK_MAX) break_cnt = break_cnt + 1'b1;

    if (run_mode == MODE_CALIB) begin
      if (item.sample > hi_seen) hi_seen = item.sample;
      if (item.sample < lo_seen) lo_seen = item.sample;
      if (sample_cnt == calib_win) begin
        sample_cnt = '0;
        thresh = SAMPLE_W'(({1'b0, lo_seen} + {1'b0, hi_seen}) >> 1);
        hi_seen = '0;
        lo_seen = SAMPLE_MAX;
        run_mode = MODE_MEASURE;
      end
      return 1'b0;
    end

    if (sample_cnt != meas_win) return 1'b0;
    res.rpm = RPM_W'(break_cnt >> 1) * RPM_FACTOR;
    res.last_sample = item.sample;
    res.threshold_now = thresh;
    sample_cnt = '0;
    break_cnt = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      meas_win = MEASURE_WINDOW_RESET;
      calib_win = CALIB_WINDOW_RESET;
      thresh = INIT_THRESHOLD_RESET;
      run_mode = MODE_STOPPED;
      was_calibrating = 1'b0;
      sample_cnt = '0;
      break_cnt = '0;
      lo_seen = SAMPLE_MAX;
      hi_seen = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MEASURE_WINDOW: meas_win = cfg_data;
          REG_CALIB_WINDOW:   calib_win = cfg_data;
          REG_INIT_THRESHOLD: thresh = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (advance_tach(in_data, reading)) expected_readings.push_back(reading);
      end

      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          fails++;
          $display("%0t: reading rpm=%0d last_sample=%0d threshold=%0d, none expected",
                   $time, out_data.rpm, out_data.last_sample, out_data.threshold_now);
        end else begin
          want = expected_readings.pop_front();
          if (out_data.rpm !== want.rpm || out_data.last_sample !== want.last_sample ||
              out_data.threshold_now !== want.threshold_now) begin
            fails++;
            $display("%0t: expected rpm=%0d last_sample=%0d threshold=%0d", $time,
                     want.rpm, want.last_sample, want.threshold_now);
            $display("%0t:   actual rpm=%0d last_sample=%0d threshold=%0d", $time,
                     out_data.rpm, out_data.last_sample, out_data.threshold_now);
          end
        end
      end
    end
    pending <= expected_readings.size();
  end

endmodule

@@ verif/tachometer_auto_threshold_tb.sv @@
module tachometer_auto_threshold_tb;
  import tat_pkg::*;

  localparam logic REQ_TICK      = ~REQ_PRESS;
  localparam int   HOLD_CYCLES   = 150;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   PHASES        = 8;
  localparam int   PHASE_ITEMS   = 160;
  localparam int   FINAL_ITEMS   = 100;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MEASURE_WINDOW;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   hold_req = 1'b0;
  bit                     hold_done;
  logic                   calm = 1'b0;
  int                     fails;
  int                     pending;
  bit                     running;
  int                     gap_pct;
  logic [SAMPLE_W-1:0]    lo_level;
  logic [SAMPLE_W-1:0]    hi_level;
  logic [SAMPLE_W-1:0]    cfg_thresh;

  in_t directed_items [18] = '{
    {REQ_TICK, 10'd1023}, {REQ_PRESS, 10'd0}, {REQ_TICK, 10'd0}, {REQ_TICK, 10'd1023},
    {REQ_TICK, 10'd511}, {REQ_TICK, 10'd511}, {REQ_TICK, 10'd511}, {REQ_PRESS, 10'd1023},
    {REQ_TICK, 10'd511}, {REQ_PRESS, 10'd0}, {REQ_TICK, 10'd7}, {REQ_PRESS, 10'd0},
    {REQ_PRESS, 10'd0}, {REQ_TICK, 10'd300}, {REQ_TICK, 10'd301}, {REQ_TICK, 10'd0},
    {REQ_TICK, 10'd1023}, {REQ_PRESS, 10'd0}
  };

  tachometer_auto_threshold dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tach_reading_checker reading_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // hold off once on request, otherwise stall in short random bursts unless calm
  always begin
    @(posedge clk);
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_ready <= 1'b1;
    end else if (calm || $urandom_range(0, 4) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] mw, input logic [CFG_DATA_W-1:0] cw,
                            input logic [CFG_DATA_W-1:0] th);
    write_reg(REG_MEASURE_WINDOW, mw);
    write_reg(REG_CALIB_WINDOW, cw);
    write_reg(REG_INIT_THRESHOLD, th);
    cfg_we <= 1'b0;
    cfg_thresh = th[SAMPLE_W-1:0];
  endtask

  task automatic offer(input logic req, input logic [SAMPLE_W-1:0] s);
    in_valid <= 1'b1;
    in_data <= {req, s};
    do @(posedge clk); while (!in_ready);
    if (req == REQ_PRESS) running = !running;
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // drop valid and wait until every reading is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic new_levels();
    lo_level = SAMPLE_W'($urandom_range(0, 1023));
    hi_level = SAMPLE_W'($urandom_range(lo_level, 1023));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return lo_level;
      1:       return hi_level;
      2, 3:    return SAMPLE_W'((11'(lo_level) + 11'(hi_level)) >> 1);
      4:       return cfg_thresh;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_window();
    return ($urandom_range(0, 5) == 0) ? 16'd1 : 16'($urandom_range(2, 24));
  endfunction

  task automatic run_phase(input int n);
    logic press;
    new_levels();
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) new_levels();
      press = running ? ($urandom_range(0, 79) == 0) : ($urandom_range(0, 9) != 0);
      offer(press, pick_sample());
      idle_gap();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_config(16'd2, 16'd2, 16'hFC00);
    gap_pct = 25;
    foreach (directed_items[i]) begin
      offer(directed_items[i].req_type, directed_items[i].sample);
      idle_gap();
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_config(16'd1, 16'd1, 16'd0);
        1:       set_config(16'hFFFF, 16'hFFFF, 16'd1023);
        default: set_config(pick_window(), pick_window(), 16'($urandom));
      endcase
      gap_pct = (p % 3 == 2) ? 0 : $urandom_range(10, 40);
      run_phase(PHASE_ITEMS);
      settle();
    end

    // one-sample windows, receiver holds off so the block backs up
    set_config(16'd1, 16'd1, 16'($urandom));
    gap_pct = 0;
    new_levels();
    if (running) offer(REQ_PRESS, '0);
    offer(REQ_PRESS, '0);
    offer(REQ_TICK, pick_sample());
    hold_req <= 1'b1;
    repeat (2 * HOLD_CYCLES) offer(REQ_TICK, pick_sample());
    settle();

    // last stretch with no idling on either side
    calm <= 1'b1;
    set_config(pick_window(), pick_window(), 16'($urandom));
    run_phase(FINAL_ITEMS);
    settle();

    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tat_pkg.sv
rtl/tat_core.sv
rtl/tat_obuf.sv
rtl/tachometer_auto_threshold.sv
rtl/tat_checker.sv
verif/tach_reading_checker.sv
verif/tachometer_auto_threshold_tb.sv
